// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/pak_pkg.sv -----
// Package: constants, types and tables for the planar arm kinematics block.
package pak_pkg;
   localparam int LENGTH_BITS     = 16;
   localparam int TRIG_ITERATIONS = 16;
   localparam int TABLE_SIZE      = 24;
   localparam int ITERS = (TRIG_ITERATIONS < TABLE_SIZE) ? TRIG_ITERATIONS : TABLE_SIZE;
   localparam int ANGLE_W = 17;
   localparam int OUT_W   = 27;
   localparam int CFG_W   = 16;
   localparam int IDX_W   = 2;
   localparam int TRIG_W  = 33;
   localparam int Z_W     = 24;
   localparam int SUM_W   = 19;
   localparam int LANES   = 3;
   localparam int TERM_W  = LENGTH_BITS + 10;
   localparam int PROD_W  = LENGTH_BITS + 31;

   localparam logic signed [SUM_W-1:0] FULL_TURN   = 19'sd46080;
   localparam logic signed [SUM_W-1:0] QUARTER     = 19'sd11520;
   localparam logic signed [SUM_W-1:0] HALF_TURN   = 19'sd23040;
   localparam logic signed [SUM_W-1:0] THREE_QUART = 19'sd34560;
   localparam logic signed [TRIG_W-1:0] GAIN_Q30   = 33'sd652032874;
   localparam logic signed [TRIG_W-1:0] ONE_Q30    = 33'sd1073741824;

   typedef enum logic [IDX_W-1:0] {
      REG_LINK_ONE   = 2'd0,
      REG_LINK_TWO   = 2'd1,
      REG_LINK_THREE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [Z_W-1:0]    z;
   } cordic_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] s;
      logic signed [TERM_W-1:0] c;
   } term_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input int i);
      logic signed [Z_W-1:0] t [TABLE_SIZE];
      t = '{24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945, 24'sd234379,
            24'sd117304, 24'sd58666, 24'sd29335, 24'sd14668, 24'sd7334, 24'sd3667,
            24'sd1833, 24'sd917, 24'sd458, 24'sd229, 24'sd115, 24'sd57, 24'sd29,
            24'sd14, 24'sd7, 24'sd4, 24'sd2, 24'sd1, 24'sd0};
      return t[i];
   endfunction
endpackage

// ----- hw/rtl/pak_stream_if.sv -----
// Valid/ready stream interface carrying a transaction payload.
interface pak_stream_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pak_lane.sv -----
// One lane: angle fold, pipelined CORDIC, clamp, length scaling with rounding.
module pak_lane
   import pak_pkg::*;
(
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [SUM_W-1:0]       angle,
   input  logic        [LENGTH_BITS-1:0] length,
   output term_type                      term
);
   localparam int DEPTH = ITERS + 2;
   localparam int RW    = SUM_W + 2;

   logic signed [SUM_W-1:0] r;
   logic signed [RW-1:0]    cand;
   logic                    flip_c;
   logic signed [SUM_W-1:0] zf;
   cordic_type              st_ff [ITERS+1];
   logic                    flip_ff [ITERS+1];
   logic signed [TRIG_W-1:0] sn_ff, cs_ff;
   logic [PROD_W-1:0]       ps_ff, pc_ff;
   logic                    ns_ff, nc_ff;
   logic [LENGTH_BITS-1:0]  len_ff [DEPTH];

   // full-turn reduction: pick the one offset that lands in [0, 360)
   always_comb begin
      r    = '0;
      cand = '0;
      for (int k = 0; k < 10; k++) begin
         cand = RW'(angle) + RW'(FULL_TURN) * RW'(5 - k);
         if (cand >= 0 && cand < RW'(FULL_TURN)) r = SUM_W'(cand);
      end
      flip_c = 1'b0;
      if (r <= QUARTER) zf = r;
      else if (r < THREE_QUART) begin
         zf = r - HALF_TURN;
         flip_c = 1'b1;
      end else zf = r - FULL_TURN;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0].x <= GAIN_Q30;
         st_ff[0].y <= '0;
         st_ff[0].z <= Z_W'(zf) <<< 9;
         flip_ff[0] <= flip_c;
         len_ff[0]  <= length;
         for (int i = 0; i < ITERS; i++) begin
            if (!st_ff[i].z[Z_W-1]) begin
               st_ff[i+1].x <= st_ff[i].x - (st_ff[i].y >>> i);
               st_ff[i+1].y <= st_ff[i].y + (st_ff[i].x >>> i);
               st_ff[i+1].z <= st_ff[i].z - atan_entry(i);
            end else begin
               st_ff[i+1].x <= st_ff[i].x + (st_ff[i].y >>> i);
               st_ff[i+1].y <= st_ff[i].y - (st_ff[i].x >>> i);
               st_ff[i+1].z <= st_ff[i].z + atan_entry(i);
            end
            flip_ff[i+1] <= flip_ff[i];
         end
         for (int i = 1; i < DEPTH; i++) len_ff[i] <= len_ff[i-1];
      end
   end

   function automatic logic signed [TRIG_W-1:0] clampf(input logic signed [TRIG_W-1:0] v,
                                                       input logic f);
      logic signed [TRIG_W-1:0] c;
      c = (v > ONE_Q30) ? ONE_Q30 : ((v < -ONE_Q30) ? -ONE_Q30 : v);
      return f ? -c : c;
   endfunction

   function automatic logic [31:0] mag(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W-1:0] a;
      a = v[TRIG_W-1] ? -v : v;
      return a[31:0];
   endfunction

   logic [PROD_W-1:0] rs, rc;
   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff <= clampf(st_ff[ITERS].y, flip_ff[ITERS]);
         cs_ff <= clampf(st_ff[ITERS].x, flip_ff[ITERS]);
         ps_ff <= PROD_W'(len_ff[ITERS+1]) * PROD_W'(mag(sn_ff));
         pc_ff <= PROD_W'(len_ff[ITERS+1]) * PROD_W'(mag(cs_ff));
         ns_ff <= sn_ff[TRIG_W-1];
         nc_ff <= cs_ff[TRIG_W-1];
      end
   end

   always_comb begin
      rs = (ps_ff + (PROD_W'(1) << 21)) >> 22;
      rc = (pc_ff + (PROD_W'(1) << 21)) >> 22;
      term.s = ns_ff ? -$signed(TERM_W'(rs)) : $signed(TERM_W'(rs));
      term.c = nc_ff ? -$signed(TERM_W'(rc)) : $signed(TERM_W'(rc));
   end
endmodule

// ----- hw/rtl/planar_arm_kinematics_jacobian.sv -----
// Top level: three CORDIC lanes, merge stage and output skid register.
// channel | dir | payload
// req_    | in  | joint_one/two/three_angle, 17 b signed each
// rsp_    | out | tip_x, tip_y, six Jacobian terms, 27 b signed each
// csr_    | in  | we, index 2 b, data 16 b
// One transaction per cycle while back-pressure does not stall the pipe; a result is
// registered in the fold stage, CORDIC stage chain, clamp, scaling multiply and skid.
// Synchronous active-high reset clears the valid pipe and the link lengths.
// Back-pressure stalls the whole pipe; a skid register holds one result.
module planar_arm_kinematics_jacobian
   import pak_pkg::*;
(
   input logic clock,
   input logic reset,
   pak_stream_if.sink   req,
   pak_stream_if.source rsp,
   input logic             csr_we,
   input logic [IDX_W-1:0] csr_index,
   input logic [CFG_W-1:0] csr_data
);
`include "assert_macros.svh"
   localparam int LAT = ITERS + 3;

   logic [LENGTH_BITS-1:0] len_ff [LANES];
   logic [LAT-1:0]         vld_ff;
   logic                   en;
   logic                   full_ff;
   logic [8*OUT_W-1:0]     skid_ff, merged_in;
   term_type               t [LANES];
   logic signed [SUM_W-1:0] a [LANES];
   logic signed [ANGLE_W-1:0] j [LANES];

   assign en = !(vld_ff[LAT-1] && full_ff && !rsp.ready) && !full_ff || rsp.ready
               || !vld_ff[LAT-1];
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) len_ff[i] <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_LINK_ONE:   len_ff[0] <= LENGTH_BITS'(csr_data);
            REG_LINK_TWO:   len_ff[1] <= LENGTH_BITS'(csr_data);
            REG_LINK_THREE: len_ff[2] <= LENGTH_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++)
         j[i] = $signed(req.data[ANGLE_W*i +: ANGLE_W]);
      a[0] = SUM_W'(j[0]);
      a[1] = a[0] + SUM_W'(j[1]);
      a[2] = a[1] + SUM_W'(j[2]);
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      pak_lane u_lane (.clock(clock), .en(en), .angle(a[g]), .length(len_ff[g]),
                       .term(t[g]));
   end

   logic signed [OUT_W-1:0] sx, cx, c23, s23, c3, s3;
   always_comb begin
      c3  = OUT_W'(t[2].c);
      s3  = OUT_W'(t[2].s);
      c23 = OUT_W'(t[1].c) + c3;
      s23 = OUT_W'(t[1].s) + s3;
      cx  = OUT_W'(t[0].c) + c23;
      sx  = OUT_W'(t[0].s) + s23;
      merged_in = {-s3, -s23, -sx, c3, c23, cx, cx, sx};
   end

   // en false only when the skid holds a result and the pipe head is valid and stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         if (en) vld_ff <= {vld_ff[LAT-2:0], req.valid};
         if (rsp.ready || !full_ff) full_ff <= en && vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if ((rsp.ready || !full_ff) && en && vld_ff[LAT-1]) skid_ff <= merged_in;
   end

   assign rsp.valid = full_ff;
   assign rsp.data  = skid_ff;

   `ASSERT_IMPL(a_stall_hold, clock, reset, !req.ready, full_ff && vld_ff[LAT-1])
   `ASSERT_NEXT(a_keep, clock, reset, full_ff && !rsp.ready, full_ff)
   `ASSERT_NEXT(a_data_hold, clock, reset, full_ff && !rsp.ready, $stable(skid_ff))
endmodule

// ----- test/planar_arm_kinematics_jacobian_test.sv -----
// Testbench for the planar arm kinematics and Jacobian block.
`timescale 1ns / 100ps

module planar_arm_kinematics_jacobian_test;
   import pak_pkg::*;

   localparam int REQ_W = 3 * ANGLE_W;
   localparam int RSP_W = 8 * OUT_W;
   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = ITERS + 12;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint ANGLE_FULL = 46080;
   localparam longint ANGLE_QUARTER = 11520;
   localparam longint ANGLE_HALF = 23040;
   localparam longint ANGLE_3QUARTER = 34560;
   localparam longint UNITS_TO_Z = 512;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = REG_LINK_ONE;
   logic [CFG_W-1:0] csr_data = '0;

   pak_stream_if #(.W(REQ_W)) req_if ();
   pak_stream_if #(.W(RSP_W)) rsp_if ();

   planar_arm_kinematics_jacobian dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   longint link_len [3];
   logic [RSP_W-1:0] pending_poses [$];
   int errors = 0;
   longint cycle_count = 0;
   bit no_idle = 0;
   bit long_hold = 0;
   string field_names [8] = '{"tip_x", "tip_y", "jac_x_joint_one", "jac_x_joint_two",
      "jac_x_joint_three", "jac_y_joint_one", "jac_y_joint_two", "jac_y_joint_three"};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void sin_cos(input longint angle, output longint sn, output longint cs);
      longint r, x, y, z, dx, dy;
      bit flip;
      r = angle % ANGLE_FULL;
      flip = 0;
      if (r < 0) r += ANGLE_FULL;
      if (r <= ANGLE_QUARTER) z = r;
      else if (r < ANGLE_3QUARTER) begin
         z = r - ANGLE_HALF;
         flip = 1;
      end else z = r - ANGLE_FULL;
      z *= UNITS_TO_Z;
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_entry(i));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(atan_entry(i));
         end
      end
      if (x > ONE_Q30) x = ONE_Q30;
      if (x < -longint'(ONE_Q30)) x = -longint'(ONE_Q30);
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -longint'(ONE_Q30)) y = -longint'(ONE_Q30);
      if (flip) begin
         x = -x;
         y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   function automatic longint scaled(input longint len, input longint t);
      longint mag, p;
      mag = (t < 0) ? -t : t;
      p = (len * mag + (longint'(1) << 21)) >>> 22;
      return (t < 0) ? -p : p;
   endfunction

   function automatic logic [RSP_W-1:0] pose_and_jacobian(input logic [REQ_W-1:0] angles);
      longint a [3];
      longint s [3];
      longint c [3];
      longint sn, cs;
      longint v [8];
      logic [RSP_W-1:0] packed_out;
      a[0] = longint'($signed(angles[0 +: ANGLE_W]));
      a[1] = a[0] + longint'($signed(angles[ANGLE_W +: ANGLE_W]));
      a[2] = a[1] + longint'($signed(angles[2*ANGLE_W +: ANGLE_W]));
      for (int k = 0; k < 3; k++) begin
         sin_cos(a[k], sn, cs);
         s[k] = scaled(link_len[k], sn);
         c[k] = scaled(link_len[k], cs);
      end
      v[0] = s[0] + s[1] + s[2];
      v[1] = c[0] + c[1] + c[2];
      v[2] = v[1];
      v[3] = c[1] + c[2];
      v[4] = c[2];
      v[5] = -v[0];
      v[6] = -(s[1] + s[2]);
      v[7] = -s[2];
      for (int k = 0; k < 8; k++) packed_out[OUT_W*k +: OUT_W] = v[k][OUT_W-1:0];
      return packed_out;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         pending_poses.push_back(pose_and_jacobian(req_if.data));
   end

   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, rsp_if.data);
            errors++;
         end else begin
            want = pending_poses.pop_front();
            for (int k = 0; k < 8; k++) begin
               if (want[OUT_W*k +: OUT_W] !== rsp_if.data[OUT_W*k +: OUT_W]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, field_names[k],
                     $signed(want[OUT_W*k +: OUT_W]),
                     $signed(rsp_if.data[OUT_W*k +: OUT_W]));
                  errors++;
               end
            end
         end
      end
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_angles(input logic [ANGLE_W-1:0] j1, input logic [ANGLE_W-1:0] j2,
                              input logic [ANGLE_W-1:0] j3, input bit gaps = 1);
      if (gaps && !no_idle && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= {j3, j2, j1};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic idle_sender();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      idle_sender();
      wait (pending_poses.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_link(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx <= REG_LINK_THREE)
         link_len[idx] = longint'(value) & ((longint'(1) << LENGTH_BITS) - 1);
   endtask

   task automatic set_lengths(input logic [CFG_W-1:0] l1, input logic [CFG_W-1:0] l2,
                              input logic [CFG_W-1:0] l3);
      write_link(REG_LINK_ONE, l1);
      write_link(REG_LINK_TWO, l2);
      write_link(REG_LINK_THREE, l3);
   endtask

   function automatic logic [ANGLE_W-1:0] random_angle();
      if ($urandom_range(0, 7) == 0) return ANGLE_W'($urandom);
      return ANGLE_W'(longint'($urandom_range(0, 92160)) - ANGLE_FULL);
   endfunction

   task automatic test_reset_lengths();
      send_angles(17'd0, 17'd0, 17'd0);
      send_angles(17'd11520, 17'd5000, -17'sd3000);
      drain();
   endtask

   task automatic test_ignored_index();
      set_lengths(16'd1000, 16'd2000, 16'd3000);
      write_link(REG_UNUSED, 16'hFFFF);
      send_angles(17'd3000, 17'd6000, 17'd9000);
      drain();
   endtask

   task automatic test_directed_angles();
      logic [ANGLE_W-1:0] corner [12];
      corner = '{17'd0, 17'd11520, 17'd11521, 17'd23040, 17'd34559, 17'd34560,
                 17'd46080, -17'sd46080, -17'sd11520, -17'sd23040, 17'h0FFFF, 17'h10000};
      set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF);
      foreach (corner[i]) send_angles(corner[i], corner[(i + 5) % 12], corner[(i + 7) % 12]);
      send_angles(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      send_angles(17'h0AAAA, 17'h15555, 17'h0AAAA);
      drain();
      set_lengths(16'd0, 16'hFFFF, 16'd1);
      foreach (corner[i]) send_angles(corner[i], corner[11 - i], corner[(i + 3) % 12]);
      drain();
   endtask

   task automatic test_backpressure();
      long_hold = 1;
      for (int i = 0; i < 80; i++) send_angles(random_angle(), random_angle(), random_angle(), 0);
      drain();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_angles(random_angle(), random_angle(), random_angle());
      drain();
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      link_len = '{0, 0, 0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lengths();
      test_ignored_index();
      test_directed_angles();
      set_lengths(16'd40000, 16'd25000, 16'd12345);
      test_backpressure();
      for (int p = 0; p < 5; p++) begin
         set_lengths(16'($urandom), 16'($urandom), 16'($urandom));
         test_random(200);
      end
      set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF);
      no_idle = 1;
      test_random(200);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
